// ===== sv/swm_pkg.sv =====
`timescale 1ns / 1ps
package swm_pkg;

   localparam int REPORT_BITS = 80;
   localparam int HIGH_BITS   = 16;
   localparam int CODE_W      = 7;
   localparam int MAX_CODES   = 8;
   localparam int GIVEN_CODES = 5;
   localparam logic [CODE_W-1:0] ANY_CODE = 7'd127;

   typedef enum logic [1:0] {
      CMD_REPORT   = 2'd0,
      CMD_REGISTER = 2'd1,
      CMD_CHANGE   = 2'd2,
      CMD_SNAPSHOT = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      KIND_WAKE     = 2'd0,
      KIND_ACK      = 2'd1,
      KIND_SNAPSHOT = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      PASS_LOAD  = 2'd0,
      PASS_ONE   = 2'd1,
      PASS_TWO   = 2'd2,
      PASS_THREE = 2'd3
   } pass_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_EVAL,
      ST_CHOOSE,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic              hit;
      logic [CODE_W-1:0] sensor;
   } match_type;

   function automatic logic bit_at(input logic [REPORT_BITS-1:0] v,
                                   input logic [CODE_W-1:0] n);
      logic [127:0] p;
      p = 128'(v);
      return p[n];
   endfunction

   // lowest set sensor of the highest nonzero group of eight
   function automatic logic [CODE_W-1:0] pick_sensor(input logic [REPORT_BITS-1:0] v);
      logic [7:0]        grp;
      logic [2:0]        low;
      logic [CODE_W-1:0] res;
      res = '0;
      for (int g = 0; g < REPORT_BITS / 8; g++) begin
         grp = v[g*8 +: 8];
         low = '0;
         for (int j = 7; j >= 0; j--) begin
            if (grp[j]) begin
               low = 3'(j);
            end
         end
         if (grp != 8'd0) begin
            res = CODE_W'(g * 8) + CODE_W'(low);
         end
      end
      return res;
   endfunction

endpackage

// ===== sv/swm_ram.sv =====
`timescale 1ns / 1ps
module swm_ram #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 64
) (
   input  logic                             clock,
   input  logic                             we,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
   input  logic [WIDTH-1:0]                 wdata,
   input  logic                             re,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
   output logic [WIDTH-1:0]                 rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end
endmodule

// ===== sv/swm_match.sv =====
`timescale 1ns / 1ps
module swm_match #(
   parameter int CODES_PER_SLOT = 5,
   parameter int SENSOR_COUNT   = 80
) (
   input  swm_pkg::pass_type                     pass,
   input  logic [CODES_PER_SLOT*swm_pkg::CODE_W-1:0] codes,
   input  logic [CODES_PER_SLOT-1:0]             used,
   input  logic [swm_pkg::REPORT_BITS-1:0]       snap,
   input  logic [swm_pkg::REPORT_BITS-1:0]       work,
   input  logic [swm_pkg::CODE_W-1:0]            chosen,
   output swm_pkg::match_type                    result
);
   import swm_pkg::*;

   function automatic logic is_sensor(input logic [CODE_W-1:0] c);
      return 8'(c) < 8'(SENSOR_COUNT);
   endfunction

   always_comb begin
      logic [CODE_W-1:0] c;
      result = '0;
      c      = codes[CODE_W-1:0];
      case (pass)
         PASS_ONE: begin
            if (used[0] && is_sensor(c) && bit_at(snap, c)) begin
               result.hit    = 1'b1;
               result.sensor = c;
            end
         end
         PASS_TWO: begin
            // a slot led by a non-sensor code sits this pass out
            if (!(used[0] && !is_sensor(c))) begin
               for (int j = 0; j < CODES_PER_SLOT; j++) begin
                  c = codes[j*CODE_W +: CODE_W];
                  if (!result.hit && used[j] && is_sensor(c) && bit_at(work, c)) begin
                     result.hit    = 1'b1;
                     result.sensor = c;
                  end
               end
            end
         end
         PASS_THREE: begin
            for (int j = 0; j < CODES_PER_SLOT; j++) begin
               if (used[j] && codes[j*CODE_W +: CODE_W] == ANY_CODE) begin
                  result.hit    = 1'b1;
                  result.sensor = chosen;
               end
            end
         end
         default: begin
            result = '0;
         end
      endcase
   end
endmodule

// ===== sv/sensor_wait_match_table.sv =====
`timescale 1ns / 1ps
// Waiter table matched against sensor reports.
// Request channel: drive req_* and raise start; a request is taken at a
// clock edge where start is high and busy is low.
// Commands: report (store snapshot, run up to three wake passes over all
// slots), register wait (read-modify-write of one slot row), change wait
// (rewrite one slot, one ack), read snapshot (one snapshot response).
// Responses: each sits on the rsp_* ports for one cycle with rsp_strobe high;
// the receiver cannot hold them off. rsp_last marks the final response of a
// request. A report that wakes nobody gives no response.
// Timing: change and snapshot answer in the cycle after the request is taken;
// busy stays low. Register wait keeps busy through a read state and an
// evaluate state. A report keeps busy through its passes, a choose state and
// a flush state: every pass reads each slot row from the row memory and
// checks it in the next cycle. A wake response is held until the next wake is
// found or the report ends, so the last one is sent from the flush state.
// Reset: all slots empty (a per-row valid bit), snapshot zero, busy low.
module sensor_wait_match_table #(
   parameter int SLOTS          = 64,
   parameter int CODES_PER_SLOT = 5,
   parameter int SENSOR_COUNT   = 80
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  logic [1:0]   req_command,
   input  logic [5:0]   req_slot,
   input  logic [2:0]   req_wait_count,
   input  logic [6:0]   req_sensor_a,
   input  logic [6:0]   req_sensor_b,
   input  logic [6:0]   req_sensor_c,
   input  logic [6:0]   req_sensor_d,
   input  logic [6:0]   req_sensor_e,
   input  logic [63:0]  req_report_low,
   input  logic [15:0]  req_report_high,
   output logic         rsp_strobe,
   output logic [1:0]   rsp_kind,
   output logic [5:0]   rsp_woken_slot,
   output logic [6:0]   rsp_woken_sensor,
   output logic [63:0]  rsp_snapshot_low,
   output logic [15:0]  rsp_snapshot_high,
   output logic         rsp_last
);
   import swm_pkg::*;

   localparam int IDX_W  = $clog2(SLOTS > 1 ? SLOTS : 2);
   localparam int CODE_BITS = CODES_PER_SLOT * CODE_W;
   localparam int ROW_W  = CODES_PER_SLOT + CODE_BITS;
   localparam logic [REPORT_BITS-1:0] SENSE_MASK = {REPORT_BITS{1'b1}} >>
      ((SENSOR_COUNT >= REPORT_BITS) ? 0 : (REPORT_BITS - SENSOR_COUNT));
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

   state_type state_ff, state_in;
   pass_type  pass_ff, pass_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic [SLOTS-1:0]       row_valid_ff, row_valid_in;
   logic                   rd_valid_ff, rd_valid_in;
   logic [REPORT_BITS-1:0] snap_ff, snap_in;
   logic [REPORT_BITS-1:0] work_ff, work_in;
   logic [CODE_W-1:0]      chosen_ff, chosen_in;
   logic [CODE_BITS-1:0]   load_codes_ff, load_codes_in;
   logic [CODES_PER_SLOT-1:0] load_mask_ff, load_mask_in;
   logic                   pend_valid_ff, pend_valid_in;
   logic [5:0]             pend_slot_ff, pend_slot_in;
   logic [CODE_W-1:0]      pend_sensor_ff, pend_sensor_in;
   logic                   rsp_strobe_ff, rsp_strobe_in;
   logic [1:0]             rsp_kind_ff, rsp_kind_in;
   logic [5:0]             rsp_slot_ff, rsp_slot_in;
   logic [CODE_W-1:0]      rsp_sensor_ff, rsp_sensor_in;
   logic [63:0]            rsp_low_ff, rsp_low_in;
   logic [15:0]            rsp_high_ff, rsp_high_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic                   ram_we, ram_re;
   logic [IDX_W-1:0]       ram_waddr;
   logic [ROW_W-1:0]       ram_wdata, ram_rdata, row;
   logic [CODE_BITS-1:0]   req_codes;
   logic [CODES_PER_SLOT-1:0] req_mask;
   logic [CODE_BITS-1:0]   merged_codes;
   logic                   slot_ok, accept;
   match_type              match;

   swm_ram #(.WIDTH(ROW_W), .DEPTH(SLOTS)) u_rows (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (idx_ff),
      .rdata (ram_rdata)
   );

   assign row = rd_valid_ff ? ram_rdata : '0;

   swm_match #(.CODES_PER_SLOT(CODES_PER_SLOT), .SENSOR_COUNT(SENSOR_COUNT)) u_match (
      .pass   (pass_ff),
      .codes  (row[CODE_BITS-1:0]),
      .used   (row[ROW_W-1:CODE_BITS]),
      .snap   (snap_ff),
      .work   (work_ff),
      .chosen (chosen_ff),
      .result (match)
   );

   assign accept  = start && (state_ff == ST_IDLE);
   assign slot_ok = 9'(req_slot) < 9'(SLOTS);
   assign busy    = (state_ff != ST_IDLE);

   // codes of the request, the first wait_count of them saturated
   always_comb begin
      logic [CODE_W-1:0] given [MAX_CODES];
      logic [3:0]        n;
      given = '{default: '0};
      given[0] = req_sensor_a;
      given[1] = req_sensor_b;
      given[2] = req_sensor_c;
      given[3] = req_sensor_d;
      given[4] = req_sensor_e;
      n = (4'(req_wait_count) > 4'(CODES_PER_SLOT)) ? 4'(CODES_PER_SLOT)
                                                     : 4'(req_wait_count);
      req_codes = '0;
      req_mask  = '0;
      for (int j = 0; j < CODES_PER_SLOT; j++) begin
         if (j < GIVEN_CODES && 4'(j) < n) begin
            req_mask[j] = 1'b1;
            req_codes[j*CODE_W +: CODE_W] = given[j];
         end
      end
   end

   always_comb begin
      for (int j = 0; j < CODES_PER_SLOT; j++) begin
         merged_codes[j*CODE_W +: CODE_W] = load_mask_ff[j] ?
            load_codes_ff[j*CODE_W +: CODE_W] : row[j*CODE_W +: CODE_W];
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_command == CMD_REPORT) begin
               state_in = ST_READ;
            end else if (accept && req_command == CMD_REGISTER && slot_ok) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (pass_ff == PASS_LOAD) begin
               state_in = ST_IDLE;
            end else if (idx_ff == LAST_IDX) begin
               unique case (pass_ff)
                  PASS_ONE:   state_in = ST_READ;
                  PASS_TWO:   state_in = ST_CHOOSE;
                  default:    state_in = ST_FLUSH;
               endcase
            end else begin
               state_in = ST_READ;
            end
         end
         ST_CHOOSE: begin
            state_in = (work_ff != '0) ? ST_READ : ST_FLUSH;
         end
         ST_FLUSH: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      pass_in        = pass_ff;
      idx_in         = idx_ff;
      row_valid_in   = row_valid_ff;
      rd_valid_in    = rd_valid_ff;
      snap_in        = snap_ff;
      work_in        = work_ff;
      chosen_in      = chosen_ff;
      load_codes_in  = load_codes_ff;
      load_mask_in   = load_mask_ff;
      pend_valid_in  = pend_valid_ff;
      pend_slot_in   = pend_slot_ff;
      pend_sensor_in = pend_sensor_ff;
      rsp_strobe_in  = 1'b0;
      rsp_kind_in    = rsp_kind_ff;
      rsp_slot_in    = rsp_slot_ff;
      rsp_sensor_in  = rsp_sensor_ff;
      rsp_low_in     = rsp_low_ff;
      rsp_high_in    = rsp_high_ff;
      rsp_last_in    = rsp_last_ff;
      ram_we         = 1'b0;
      ram_re         = 1'b0;
      ram_waddr      = idx_ff;
      ram_wdata      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_command)
                  CMD_REPORT: begin
                     snap_in = {req_report_high, req_report_low} & SENSE_MASK;
                     work_in = {req_report_high, req_report_low} & SENSE_MASK;
                     idx_in  = '0;
                     pass_in = PASS_ONE;
                  end
                  CMD_REGISTER: begin
                     idx_in        = IDX_W'(req_slot);
                     pass_in       = PASS_LOAD;
                     load_codes_in = req_codes;
                     load_mask_in  = req_mask;
                  end
                  CMD_CHANGE: begin
                     if (slot_ok) begin
                        ram_we    = 1'b1;
                        ram_waddr = IDX_W'(req_slot);
                        ram_wdata = {req_mask, req_codes};
                        row_valid_in[IDX_W'(req_slot)] = 1'b1;
                     end
                     rsp_strobe_in = 1'b1;
                     rsp_kind_in   = KIND_ACK;
                     rsp_slot_in   = req_slot;
                     rsp_sensor_in = '0;
                     rsp_low_in    = '0;
                     rsp_high_in   = '0;
                     rsp_last_in   = 1'b1;
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                     rsp_kind_in   = KIND_SNAPSHOT;
                     rsp_slot_in   = '0;
                     rsp_sensor_in = '0;
                     rsp_low_in    = snap_ff[63:0];
                     rsp_high_in   = snap_ff[REPORT_BITS-1:64];
                     rsp_last_in   = 1'b1;
                  end
               endcase
            end
         end
         ST_READ: begin
            ram_re      = 1'b1;
            rd_valid_in = row_valid_ff[idx_ff];
         end
         ST_EVAL: begin
            if (pass_ff == PASS_LOAD) begin
               ram_we    = 1'b1;
               ram_wdata = {row[ROW_W-1:CODE_BITS] | load_mask_ff, merged_codes};
               row_valid_in[idx_ff] = 1'b1;
            end else begin
               if (match.hit) begin
                  // clearing a slot is dropping its row valid bit
                  row_valid_in[idx_ff] = 1'b0;
                  if (pass_ff == PASS_TWO) begin
                     work_in = work_ff & ~(REPORT_BITS'(1) << match.sensor);
                  end
                  if (pend_valid_ff) begin
                     rsp_strobe_in = 1'b1;
                     rsp_kind_in   = KIND_WAKE;
                     rsp_slot_in   = pend_slot_ff;
                     rsp_sensor_in = pend_sensor_ff;
                     rsp_low_in    = '0;
                     rsp_high_in   = '0;
                     rsp_last_in   = 1'b0;
                  end
                  pend_valid_in  = 1'b1;
                  pend_slot_in   = 6'(idx_ff);
                  pend_sensor_in = match.sensor;
               end
               if (idx_ff == LAST_IDX) begin
                  idx_in = '0;
                  if (pass_ff == PASS_ONE) begin
                     pass_in = PASS_TWO;
                  end
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         ST_CHOOSE: begin
            chosen_in = pick_sensor(work_ff);
            pass_in   = PASS_THREE;
            idx_in    = '0;
         end
         ST_FLUSH: begin
            if (pend_valid_ff) begin
               rsp_strobe_in = 1'b1;
               rsp_kind_in   = KIND_WAKE;
               rsp_slot_in   = pend_slot_ff;
               rsp_sensor_in = pend_sensor_ff;
               rsp_low_in    = '0;
               rsp_high_in   = '0;
               rsp_last_in   = 1'b1;
            end
            pend_valid_in = 1'b0;
         end
         default: begin
            pend_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         row_valid_ff  <= '0;
         snap_ff       <= '0;
         pend_valid_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         pass_ff       <= PASS_LOAD;
      end else begin
         state_ff      <= state_in;
         row_valid_ff  <= row_valid_in;
         snap_ff       <= snap_in;
         pend_valid_ff <= pend_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
         pass_ff       <= pass_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      rd_valid_ff    <= rd_valid_in;
      work_ff        <= work_in;
      chosen_ff      <= chosen_in;
      load_codes_ff  <= load_codes_in;
      load_mask_ff   <= load_mask_in;
      pend_slot_ff   <= pend_slot_in;
      pend_sensor_ff <= pend_sensor_in;
      rsp_kind_ff    <= rsp_kind_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_sensor_ff  <= rsp_sensor_in;
      rsp_low_ff     <= rsp_low_in;
      rsp_high_ff    <= rsp_high_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_kind          = rsp_kind_ff;
   assign rsp_woken_slot    = rsp_slot_ff;
   assign rsp_woken_sensor  = rsp_sensor_ff;
   assign rsp_snapshot_low  = rsp_low_ff;
   assign rsp_snapshot_high = rsp_high_ff;
   assign rsp_last          = rsp_last_ff;

`ifndef SYNTHESIS
   a_report_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_command == CMD_REPORT) |=> busy)
      else $error("report request did not start a scan");
   a_snap_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_kind != KIND_WAKE) |-> rsp_last)
      else $error("ack or snapshot response not marked last");
   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !pend_valid_ff)
      else $error("wake response left behind after a report");
`endif
endmodule

// ===== tb/tb_sensor_wait_match_table.sv =====
`timescale 1ns / 1ps
module tb_sensor_wait_match_table;
   import swm_pkg::*;

   localparam int NSLOT = 64;
   localparam int NCODE = 5;
   localparam int NSENS = 80;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      cmd_type     cmd;
      logic [5:0]  slot;
      logic [2:0]  cnt;
      logic [4:0][6:0] codes;
      logic [63:0] lo;
      logic [15:0] hi;
   } request_type;

   typedef struct packed {
      kind_type    kind;
      logic [5:0]  slot;
      logic [6:0]  sensor;
      logic [63:0] lo;
      logic [15:0] hi;
      logic        last;
   } response_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   logic [1:0]   req_command = '0;
   logic [5:0]   req_slot = '0;
   logic [2:0]   req_wait_count = '0;
   logic [6:0]   req_sensor_a = '0;
   logic [6:0]   req_sensor_b = '0;
   logic [6:0]   req_sensor_c = '0;
   logic [6:0]   req_sensor_d = '0;
   logic [6:0]   req_sensor_e = '0;
   logic [63:0]  req_report_low = '0;
   logic [15:0]  req_report_high = '0;
   logic         rsp_strobe;
   logic [1:0]   rsp_kind;
   logic [5:0]   rsp_woken_slot;
   logic [6:0]   rsp_woken_sensor;
   logic [63:0]  rsp_snapshot_low;
   logic [15:0]  rsp_snapshot_high;
   logic         rsp_last;

   sensor_wait_match_table uut (.*);

   always #5 clock = ~clock;

   request_type   pending_q[$];
   response_type  response_q[$];
   request_type   cur;
   int         taken = 0;
   int         total = 0;
   int         errors = 0;
   int         cycles = 0;

   // table mirror
   logic [6:0]  code_tab[NSLOT][NCODE];
   bit          used_tab[NSLOT][NCODE];
   logic [79:0] snap;

   initial begin
      for (int i = 0; i < NSLOT; i++)
         for (int j = 0; j < NCODE; j++) begin
            code_tab[i][j] = '0;
            used_tab[i][j] = 0;
         end
      snap = '0;
   end

   function automatic request_type mk(cmd_type c, int s, int n, int a, int b, int cc, int d,
                                      int e, logic [63:0] lo, logic [15:0] hi);
      request_type r;
      r.cmd = c;
      r.slot = 6'(s);
      r.cnt = 3'(n);
      r.codes = {7'(e), 7'(d), 7'(cc), 7'(b), 7'(a)};
      r.lo = lo;
      r.hi = hi;
      return r;
   endfunction

   function automatic void add_response(kind_type k, int s, int sn, logic [63:0] lo,
                                        logic [15:0] hi);
      response_type p;
      p.kind = k;
      p.slot = 6'(s);
      p.sensor = 7'(sn);
      p.lo = lo;
      p.hi = hi;
      p.last = 1'b0;
      response_q.push_back(p);
   endfunction

   function automatic void clear_slot(int s);
      for (int j = 0; j < NCODE; j++) begin
         code_tab[s][j] = '0;
         used_tab[s][j] = 0;
      end
   endfunction

   function automatic void load_slot(request_type r);
      int n;
      n = (r.cnt > NCODE) ? NCODE : r.cnt;
      for (int j = 0; j < n; j++) begin
         code_tab[r.slot][j] = r.codes[j];
         used_tab[r.slot][j] = 1;
      end
   endfunction

   function automatic void predict_wakes(request_type r);
      logic [79:0] work;
      logic [6:0]  c;
      int          before_n;
      bit          hit;
      bit          found;
      int          chosen;
      before_n = response_q.size();
      case (r.cmd)
         CMD_REGISTER: load_slot(r);
         CMD_CHANGE: begin
            clear_slot(r.slot);
            load_slot(r);
            add_response(KIND_ACK, r.slot, 0, '0, '0);
         end
         CMD_SNAPSHOT: add_response(KIND_SNAPSHOT, 0, 0, snap[63:0], snap[79:64]);
         default: begin
            snap = {r.hi, r.lo};
            work = snap;
            // first code, no consumption
            for (int i = 0; i < NSLOT; i++) begin
               c = code_tab[i][0];
               if (used_tab[i][0] && c < NSENS && snap[c]) begin
                  add_response(KIND_WAKE, i, c, '0, '0);
                  clear_slot(i);
               end
            end
            // first set code, consuming its bit
            for (int i = 0; i < NSLOT; i++) begin
               hit = 0;
               if (!(used_tab[i][0] && code_tab[i][0] >= NSENS)) begin
                  for (int j = 0; j < NCODE; j++) begin
                     c = code_tab[i][j];
                     if (!hit && used_tab[i][j] && c < NSENS && work[c]) begin
                        hit = 1;
                        work[c] = 1'b0;
                        add_response(KIND_WAKE, i, c, '0, '0);
                        clear_slot(i);
                     end
                  end
               end
            end
            // any-code waiters
            found = 0;
            chosen = 0;
            for (int g = NSENS / 8 - 1; g >= 0; g--) begin
               if (!found && work[g*8 +: 8] != 8'd0) begin
                  found = 1;
                  for (int j = 7; j >= 0; j--)
                     if (work[g*8 + j]) chosen = g * 8 + j;
               end
            end
            if (found) begin
               for (int i = 0; i < NSLOT; i++) begin
                  hit = 0;
                  for (int j = 0; j < NCODE; j++)
                     if (used_tab[i][j] && code_tab[i][j] == ANY_CODE) hit = 1;
                  if (hit) begin
                     add_response(KIND_WAKE, i, chosen, '0, '0);
                     clear_slot(i);
                  end
               end
            end
         end
      endcase
      if (response_q.size() > before_n) response_q[response_q.size() - 1].last = 1'b1;
   endfunction

   function automatic int rand_code();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(0, 79);
      if (r < 85) return ANY_CODE;
      return $urandom_range(0, 127);
   endfunction

   function automatic request_type rand_request();
      request_type r;
      logic [79:0] bits;
      int          p;
      p = $urandom_range(0, 99);
      r = mk(CMD_REGISTER, $urandom_range(0, 63), $urandom_range(0, 7), rand_code(),
             rand_code(), rand_code(), rand_code(), rand_code(), {$urandom, $urandom},
             16'($urandom));
      if (p >= 40 && p < 55) r.cmd = CMD_CHANGE;
      else if (p >= 55 && p < 63) r.cmd = CMD_SNAPSHOT;
      else if (p >= 63) begin
         r.cmd = CMD_REPORT;
         if ($urandom_range(0, 4) != 0) begin
            // sparse report so the wake passes see contention
            bits = '0;
            repeat ($urandom_range(1, 4)) bits[$urandom_range(0, 79)] = 1'b1;
            r.lo = bits[63:0];
            r.hi = bits[79:64];
         end
      end
      return r;
   endfunction

   // request driver
   always @(posedge clock) begin
      bit idle;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            predict_wakes(cur);
            taken++;
         end
         if (!start || !busy) begin
            idle = (taken < 40 || taken > 75) && $urandom_range(0, 99) < 24;
            if (pending_q.size() > 0 && !idle) begin
               cur = pending_q.pop_front();
               req_command <= cur.cmd;
               req_slot <= cur.slot;
               req_wait_count <= cur.cnt;
               req_sensor_a <= cur.codes[0];
               req_sensor_b <= cur.codes[1];
               req_sensor_c <= cur.codes[2];
               req_sensor_d <= cur.codes[3];
               req_sensor_e <= cur.codes[4];
               req_report_low <= cur.lo;
               req_report_high <= cur.hi;
               start <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      response_type e;
      if (!reset && rsp_strobe) begin
         if (response_q.size() == 0) begin
            $error("unexpected response kind=%0d slot=%0d", rsp_kind, rsp_woken_slot);
            errors++;
         end else begin
            e = response_q.pop_front();
            if (rsp_kind !== e.kind) begin
               $error("kind: expected %0d, got %0d", e.kind, rsp_kind);
               errors++;
            end
            if (rsp_woken_slot !== e.slot) begin
               $error("woken_slot: expected %0d, got %0d", e.slot, rsp_woken_slot);
               errors++;
            end
            if (rsp_woken_sensor !== e.sensor) begin
               $error("woken_sensor: expected %0d, got %0d", e.sensor, rsp_woken_sensor);
               errors++;
            end
            if (rsp_snapshot_low !== e.lo) begin
               $error("snapshot_low: expected %h, got %h", e.lo, rsp_snapshot_low);
               errors++;
            end
            if (rsp_snapshot_high !== e.hi) begin
               $error("snapshot_high: expected %h, got %h", e.hi, rsp_snapshot_high);
               errors++;
            end
            if (rsp_last !== e.last) begin
               $error("last: expected %0d, got %0d", e.last, rsp_last);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      pending_q.push_back(mk(CMD_SNAPSHOT, 0, 0, 0, 0, 0, 0, 0, '0, '0));
      pending_q.push_back(mk(CMD_REGISTER, 0, 1, 5, 0, 0, 0, 0, '0, '0));
      pending_q.push_back(mk(CMD_REGISTER, 1, 2, 126, 5, 0, 0, 0, '0, '0));
      pending_q.push_back(mk(CMD_REGISTER, 2, 3, 70, 5, 9, 0, 0, '0, '0));
      pending_q.push_back(mk(CMD_REGISTER, 3, 2, 60, 5, 0, 0, 0, '0, '0));
      // count above five saturates; any-code as first entry
      pending_q.push_back(mk(CMD_CHANGE, 63, 7, 127, 127, 127, 127, 127, '0, '0));
      pending_q.push_back(mk(CMD_REGISTER, 10, 0, 33, 34, 35, 36, 37, '0, '0));
      pending_q.push_back(mk(CMD_REGISTER, 4, 5, 1, 2, 3, 4, 127, '0, '0));
      pending_q.push_back(mk(CMD_REGISTER, 5, 7, 80, 127, 0, 0, 0, '0, '0));
      pending_q.push_back(mk(CMD_REPORT, 0, 0, 0, 0, 0, 0, 0, 64'h20, 16'h0300));
      pending_q.push_back(mk(CMD_SNAPSHOT, 0, 0, 0, 0, 0, 0, 0, '0, '0));
      pending_q.push_back(mk(CMD_REGISTER, 6, 5, 79, 0, 127, 64, 63, '0, '0));
      pending_q.push_back(mk(CMD_REGISTER, 7, 5, 0, 0, 0, 0, 0, '0, '0));
      pending_q.push_back(mk(CMD_REGISTER, 8, 3, 100, 126, 127, 0, 0, '0, '0));
      pending_q.push_back(mk(CMD_REPORT, 0, 0, 0, 0, 0, 0, 0, '1, '1));
      pending_q.push_back(mk(CMD_SNAPSHOT, 0, 0, 0, 0, 0, 0, 0, '0, '0));
      pending_q.push_back(mk(CMD_CHANGE, 5, 0, 127, 127, 127, 127, 127, '0, '0));
      pending_q.push_back(mk(CMD_REPORT, 0, 0, 0, 0, 0, 0, 0, '0, '0));
      pending_q.push_back(mk(CMD_REGISTER, 9, 2, 50, 79, 0, 0, 0, '0, '0));
      pending_q.push_back(mk(CMD_REGISTER, 11, 1, 127, 0, 0, 0, 0, '0, '0));
      pending_q.push_back(mk(CMD_REPORT, 0, 0, 0, 0, 0, 0, 0, '0, 16'h8000));
      pending_q.push_back(mk(CMD_SNAPSHOT, 0, 0, 0, 0, 0, 0, 0, '0, '0));
      repeat (100) pending_q.push_back(rand_request());
      total = pending_q.size();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      wait (taken == total);
      wait (response_q.size() == 0);
      repeat (400) @(posedge clock);
      if (errors == 0 && response_q.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
